FILE: rtl/mcpd_pkg.sv
// Shared widths, codes and types for the magnetorquer cross-product desaturation block.
package mcpd_pkg;

    localparam int ERR_W        = 32;
    localparam int FIELD_W      = 18;
    localparam int GAIN_W       = 32;
    localparam int DUTY_W       = 17;
    localparam int OUT_W        = 32;
    localparam int ADDR_W       = 3;

    localparam int PROD_W       = ERR_W + FIELD_W;
    localparam int CROSS_W      = PROD_W + 1;
    localparam int CMAG_W       = CROSS_W - 1;
    localparam int SUM_W        = 36;
    localparam int TPROD_W      = CROSS_W + FIELD_W;
    localparam int TMAG_W       = TPROD_W - 1;
    localparam int DEN_W        = SUM_W + DUTY_W - 1;
    localparam int DSCALE_W     = 8;
    localparam int DEN1_W       = DEN_W + DSCALE_W;
    localparam int GK_W         = 62;

    localparam int CL_W         = 25;
    localparam int GL_W         = 31;
    localparam int PP_W         = CL_W + GL_W;
    localparam int M_W          = PP_W + GL_W + 1;
    localparam int NUM1_W       = CMAG_W + GK_W;
    localparam int TL_W         = 34;
    localparam int TQ_W         = TL_W + GAIN_W;
    localparam int NUM2_W       = TMAG_W + GAIN_W;

    localparam int QUO_W        = 33;
    localparam int DIV_LAT      = QUO_W + 4;
    localparam int FRONT_STAGES = 7;

    localparam logic [DUTY_W-1:0] DUTY_ONE = 17'd65536;
    localparam logic [29:0]       NANO_INV = 30'd1000000000;

    localparam logic REG_GAIN = 1'b0;
    localparam logic REG_DUTY = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_UNCONF,
        STATUS_ZERO_FIELD,
        STATUS_OVERFLOW
    } status_t;

    typedef struct packed {
        logic             fits;
        logic [OUT_W-1:0] quo;
    } div_res_t;

endpackage

FILE: rtl/mcpd_div.sv
// Pipelined restoring divider with round-to-nearest and signed 32-bit range check.
module mcpd_div #(
    parameter int NUM_W = mcpd_pkg::NUM1_W,
    parameter int DEN_W = mcpd_pkg::DEN1_W
) (
    input  logic               clk,
    input  logic [NUM_W-1:0]   num,
    input  logic [DEN_W-1:0]   den,
    input  logic               neg,
    output mcpd_pkg::div_res_t res
);

    localparam int QW = mcpd_pkg::QUO_W;
    localparam int HW = NUM_W - QW;
    localparam int CW = (HW > DEN_W) ? HW : DEN_W;
    localparam int OW = mcpd_pkg::OUT_W;
    localparam logic [QW:0] LIM_NEG = (QW + 1)'(64'd1 << (OW - 1));
    localparam logic [QW:0] LIM_POS = LIM_NEG - 1'b1;

    logic [DEN_W-1:0]   rem_reg [QW+1];
    logic [QW-1:0]      low_reg [QW];
    logic [QW-1:0]      quo_reg [QW+1];
    logic [DEN_W-1:0]   den_reg [QW+1];
    logic [QW:0]        ovf_reg;
    logic [QW:0]        neg_reg;

    logic [DEN_W:0]     trial [QW];
    logic [DEN_W:0]     diff [QW];
    logic [DEN_W-1:0]   rem_next [QW];
    logic [QW-1:0]      take_next;
    logic               ovf_next;

    logic [QW-1:0]      q1_reg;
    logic               up1_reg;
    logic               ovf1_reg;
    logic               neg1_reg;
    logic [QW:0]        qr2_reg;
    logic               ovf2_reg;
    logic               neg2_reg;
    logic               up_next;
    logic               fits_next;
    logic [OW-1:0]      quo_next;
    mcpd_pkg::div_res_t res_reg;

    always_comb
    begin
        ovf_next = CW'(num[NUM_W-1:QW]) >= CW'(den);
        for (int k = 0; k < QW; k++)
        begin
            trial[k]     = {rem_reg[k], low_reg[k][QW-1]};
            diff[k]      = trial[k] - {1'b0, den_reg[k]};
            take_next[k] = trial[k] >= {1'b0, den_reg[k]};
            rem_next[k]  = take_next[k] ? diff[k][DEN_W-1:0] : trial[k][DEN_W-1:0];
        end
        up_next   = {rem_reg[QW], 1'b0} >= {1'b0, den_reg[QW]};
        fits_next = !ovf2_reg && (qr2_reg <= (neg2_reg ? LIM_NEG : LIM_POS));
        quo_next  = neg2_reg ? (-qr2_reg[OW-1:0]) : qr2_reg[OW-1:0];
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= DEN_W'(num[NUM_W-1:QW]);
        low_reg[0] <= num[QW-1:0];
        quo_reg[0] <= '0;
        den_reg[0] <= den;
        ovf_reg[0] <= ovf_next;
        neg_reg[0] <= neg;
        for (int k = 0; k < QW; k++)
        begin
            rem_reg[k+1] <= rem_next[k];
            if (k < QW - 1)
            begin
                low_reg[k+1] <= {low_reg[k][QW-2:0], 1'b0};
            end
            quo_reg[k+1] <= {quo_reg[k][QW-2:0], take_next[k]};
            den_reg[k+1] <= den_reg[k];
            ovf_reg[k+1] <= ovf_reg[k];
            neg_reg[k+1] <= neg_reg[k];
        end
        q1_reg       <= quo_reg[QW];
        up1_reg      <= up_next;
        ovf1_reg     <= ovf_reg[QW];
        neg1_reg     <= neg_reg[QW];
        qr2_reg      <= {1'b0, q1_reg} + (QW + 1)'(up1_reg);
        ovf2_reg     <= ovf1_reg;
        neg2_reg     <= neg1_reg;
        res_reg.fits <= fits_next;
        res_reg.quo  <= quo_next;
    end

    assign res = res_reg;

endmodule

FILE: rtl/magnetorquer_cross_product_desat.sv
// Top level of the magnetorquer cross-product desaturation datapath with its register port.
//
// The block accepts one transaction per clock cycle (busy is always low) and
// raises a one-cycle done strobe with the result after 45 register stages,
// the first of which loads at the accepting edge: 7 stages of cross
// products, scaling and partial-product multiplies, then 37 stages in the
// six parallel divider pipelines, which resolve one quotient bit per stage
// over 33 stages, plus the output register. The receiver cannot stall the
// block, so it must take each result in the cycle where done is high. Gain and
// duty are to be written through the APB port only while no transaction is in
// flight; the block itself does not enforce this.
module magnetorquer_cross_product_desat (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mcpd_pkg::ADDR_W-1:0]          paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [mcpd_pkg::ERR_W-1:0]    err_x,
    input  logic signed [mcpd_pkg::ERR_W-1:0]    err_y,
    input  logic signed [mcpd_pkg::ERR_W-1:0]    err_z,
    input  logic signed [mcpd_pkg::FIELD_W-1:0]  field_x,
    input  logic signed [mcpd_pkg::FIELD_W-1:0]  field_y,
    input  logic signed [mcpd_pkg::FIELD_W-1:0]  field_z,
    output logic                                 done,
    output logic signed [mcpd_pkg::OUT_W-1:0]    dipole_x,
    output logic signed [mcpd_pkg::OUT_W-1:0]    dipole_y,
    output logic signed [mcpd_pkg::OUT_W-1:0]    dipole_z,
    output logic signed [mcpd_pkg::OUT_W-1:0]    torque_x,
    output logic signed [mcpd_pkg::OUT_W-1:0]    torque_y,
    output logic signed [mcpd_pkg::OUT_W-1:0]    torque_z,
    output logic [1:0]                           status
);

    localparam int PIPE = mcpd_pkg::FRONT_STAGES + mcpd_pkg::DIV_LAT;

    logic [mcpd_pkg::GAIN_W-1:0] gain_reg;
    logic [mcpd_pkg::DUTY_W-1:0] duty_reg;
    logic [mcpd_pkg::GK_W-1:0]   gk_reg;
    logic                        cfg_wr;
    logic                        accept;

    logic [PIPE-1:0] vld_reg;
    logic [PIPE-1:0] unconf_reg;
    logic [PIPE-1:0] zf_reg;

    logic signed [mcpd_pkg::PROD_W-1:0]   p1_reg [6];
    logic [mcpd_pkg::SUM_W-1:0]           sq1_reg [3];
    logic signed [mcpd_pkg::FIELD_W-1:0]  b1_reg [3];

    logic signed [mcpd_pkg::CROSS_W-1:0]  c2_reg [3];
    logic [mcpd_pkg::SUM_W-1:0]           s2_reg;
    logic signed [mcpd_pkg::FIELD_W-1:0]  b2_reg [3];

    logic [mcpd_pkg::CMAG_W-1:0]          cmag3_reg [3];
    logic [2:0]                           cneg3_reg;
    logic signed [mcpd_pkg::TPROD_W-1:0]  tp3_reg [6];
    logic [mcpd_pkg::DEN_W-1:0]           d3_reg;

    logic [mcpd_pkg::PP_W-1:0]            pp4_reg [3][4];
    logic signed [mcpd_pkg::TPROD_W-1:0]  t4_reg [3];
    logic [2:0]                           cneg4_reg;
    logic [mcpd_pkg::DEN_W-1:0]           d4_reg;

    logic [mcpd_pkg::M_W-1:0]             m5a_reg [3];
    logic [mcpd_pkg::M_W-1:0]             m5b_reg [3];
    logic [mcpd_pkg::TMAG_W-1:0]          tmag5_reg [3];
    logic [2:0]                           tneg5_reg;
    logic [2:0]                           cneg5_reg;
    logic [mcpd_pkg::DEN_W-1:0]           d5_reg;

    logic [mcpd_pkg::NUM1_W-1:0]          n1_6_reg [3];
    logic [mcpd_pkg::TQ_W-1:0]            tqlo6_reg [3];
    logic [mcpd_pkg::TQ_W-1:0]            tqhi6_reg [3];
    logic [2:0]                           tneg6_reg;
    logic [2:0]                           cneg6_reg;
    logic [mcpd_pkg::DEN_W-1:0]           d6_reg;

    logic [mcpd_pkg::NUM1_W-1:0]          n1_7_reg [3];
    logic [mcpd_pkg::NUM2_W-1:0]          n2_7_reg [3];
    logic [2:0]                           tneg7_reg;
    logic [2:0]                           cneg7_reg;
    logic [mcpd_pkg::DEN_W-1:0]           d7_reg;

    mcpd_pkg::div_res_t dres [3];
    mcpd_pkg::div_res_t tres [3];

    logic                              ovf_any;
    mcpd_pkg::status_t                 status_next;
    mcpd_pkg::status_t                 status_reg;
    logic                              done_reg;
    logic signed [mcpd_pkg::OUT_W-1:0] dip_reg [3];
    logic signed [mcpd_pkg::OUT_W-1:0] trq_reg [3];

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign accept = start && !busy;

    // Register port; gain times 1e9 is kept alongside gain for the dipole path.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= '0;
            duty_reg <= mcpd_pkg::DUTY_ONE;
            gk_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[mcpd_pkg::ADDR_W-1])
                mcpd_pkg::REG_GAIN:
                begin
                    gain_reg <= pwdata;
                    gk_reg   <= pwdata * mcpd_pkg::NANO_INV;
                end
                mcpd_pkg::REG_DUTY:
                begin
                    duty_reg <= pwdata[mcpd_pkg::DUTY_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[mcpd_pkg::ADDR_W-1])
            mcpd_pkg::REG_GAIN: prdata = gain_reg;
            mcpd_pkg::REG_DUTY: prdata = 32'(duty_reg);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[PIPE-2:0], accept};
            done_reg <= vld_reg[PIPE-1];
        end
    end

    always_ff @(posedge clk)
    begin
        unconf_reg <= {unconf_reg[PIPE-2:0],
                       (gain_reg == '0) || (duty_reg == '0) || (duty_reg > mcpd_pkg::DUTY_ONE)};
        zf_reg     <= {zf_reg[PIPE-2:0], (field_x == '0) && (field_y == '0) && (field_z == '0)};

        p1_reg[0]  <= err_y * field_z;
        p1_reg[1]  <= err_z * field_y;
        p1_reg[2]  <= err_z * field_x;
        p1_reg[3]  <= err_x * field_z;
        p1_reg[4]  <= err_x * field_y;
        p1_reg[5]  <= err_y * field_x;
        sq1_reg[0] <= field_x * field_x;
        sq1_reg[1] <= field_y * field_y;
        sq1_reg[2] <= field_z * field_z;
        b1_reg[0]  <= field_x;
        b1_reg[1]  <= field_y;
        b1_reg[2]  <= field_z;

        c2_reg[0] <= p1_reg[0] - p1_reg[1];
        c2_reg[1] <= p1_reg[2] - p1_reg[3];
        c2_reg[2] <= p1_reg[4] - p1_reg[5];
        s2_reg    <= sq1_reg[0] + sq1_reg[1] + sq1_reg[2];
        b2_reg    <= b1_reg;

        tp3_reg[0] <= c2_reg[1] * b2_reg[2];
        tp3_reg[1] <= c2_reg[2] * b2_reg[1];
        tp3_reg[2] <= c2_reg[2] * b2_reg[0];
        tp3_reg[3] <= c2_reg[0] * b2_reg[2];
        tp3_reg[4] <= c2_reg[0] * b2_reg[1];
        tp3_reg[5] <= c2_reg[1] * b2_reg[0];
        d3_reg     <= s2_reg * duty_reg;

        for (int i = 0; i < 3; i++)
        begin
            cmag3_reg[i] <= mcpd_pkg::CMAG_W'(c2_reg[i][mcpd_pkg::CROSS_W-1] ?
                                               -c2_reg[i] : c2_reg[i]);
            cneg3_reg[i] <= c2_reg[i][mcpd_pkg::CROSS_W-1];

            t4_reg[i]     <= tp3_reg[2*i] - tp3_reg[2*i+1];
            pp4_reg[i][0] <= cmag3_reg[i][mcpd_pkg::CL_W-1:0] *
                             gk_reg[mcpd_pkg::GL_W-1:0];
            pp4_reg[i][1] <= cmag3_reg[i][mcpd_pkg::CL_W-1:0] *
                             gk_reg[mcpd_pkg::GK_W-1:mcpd_pkg::GL_W];
            pp4_reg[i][2] <= cmag3_reg[i][mcpd_pkg::CMAG_W-1:mcpd_pkg::CL_W] *
                             gk_reg[mcpd_pkg::GL_W-1:0];
            pp4_reg[i][3] <= cmag3_reg[i][mcpd_pkg::CMAG_W-1:mcpd_pkg::CL_W] *
                             gk_reg[mcpd_pkg::GK_W-1:mcpd_pkg::GL_W];

            m5a_reg[i]   <= mcpd_pkg::M_W'(pp4_reg[i][0]) +
                            mcpd_pkg::M_W'({pp4_reg[i][1], {mcpd_pkg::GL_W{1'b0}}});
            m5b_reg[i]   <= mcpd_pkg::M_W'(pp4_reg[i][2]) +
                            mcpd_pkg::M_W'({pp4_reg[i][3], {mcpd_pkg::GL_W{1'b0}}});
            tmag5_reg[i] <= mcpd_pkg::TMAG_W'(t4_reg[i][mcpd_pkg::TPROD_W-1] ?
                                               -t4_reg[i] : t4_reg[i]);
            tneg5_reg[i] <= t4_reg[i][mcpd_pkg::TPROD_W-1];

            n1_6_reg[i]  <= mcpd_pkg::NUM1_W'(m5a_reg[i]) +
                            mcpd_pkg::NUM1_W'({m5b_reg[i], {mcpd_pkg::CL_W{1'b0}}});
            tqlo6_reg[i] <= tmag5_reg[i][mcpd_pkg::TL_W-1:0] * gain_reg;
            tqhi6_reg[i] <= tmag5_reg[i][mcpd_pkg::TMAG_W-1:mcpd_pkg::TL_W] * gain_reg;

            n1_7_reg[i]  <= n1_6_reg[i];
            n2_7_reg[i]  <= mcpd_pkg::NUM2_W'(tqlo6_reg[i]) +
                            mcpd_pkg::NUM2_W'({tqhi6_reg[i], {mcpd_pkg::TL_W{1'b0}}});
        end

        cneg4_reg <= cneg3_reg;
        cneg5_reg <= cneg4_reg;
        cneg6_reg <= cneg5_reg;
        cneg7_reg <= cneg6_reg;
        tneg6_reg <= tneg5_reg;
        tneg7_reg <= tneg6_reg;
        d4_reg    <= d3_reg;
        d5_reg    <= d4_reg;
        d6_reg    <= d5_reg;
        d7_reg    <= d6_reg;
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_div
        mcpd_div #(
            .NUM_W (mcpd_pkg::NUM1_W),
            .DEN_W (mcpd_pkg::DEN1_W)
        ) u_dip_div (
            .clk (clk),
            .num (n1_7_reg[g]),
            .den ({d7_reg, {mcpd_pkg::DSCALE_W{1'b0}}}),
            .neg (cneg7_reg[g]),
            .res (dres[g])
        );

        mcpd_div #(
            .NUM_W (mcpd_pkg::NUM2_W),
            .DEN_W (mcpd_pkg::DEN_W)
        ) u_trq_div (
            .clk (clk),
            .num (n2_7_reg[g]),
            .den (d7_reg),
            .neg (tneg7_reg[g]),
            .res (tres[g])
        );
    end

    always_comb
    begin
        ovf_any = !dres[0].fits || !dres[1].fits || !dres[2].fits ||
                  !tres[0].fits || !tres[1].fits || !tres[2].fits;
        if (unconf_reg[PIPE-1])
        begin
            status_next = mcpd_pkg::STATUS_UNCONF;
        end
        else if (zf_reg[PIPE-1])
        begin
            status_next = mcpd_pkg::STATUS_ZERO_FIELD;
        end
        else if (ovf_any)
        begin
            status_next = mcpd_pkg::STATUS_OVERFLOW;
        end
        else
        begin
            status_next = mcpd_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        for (int i = 0; i < 3; i++)
        begin
            dip_reg[i] <= (status_next == mcpd_pkg::STATUS_OK) ? dres[i].quo : '0;
            trq_reg[i] <= (status_next == mcpd_pkg::STATUS_OK) ? tres[i].quo : '0;
        end
    end

    assign done     = done_reg;
    assign dipole_x = dip_reg[0];
    assign dipole_y = dip_reg[1];
    assign dipole_z = dip_reg[2];
    assign torque_x = trq_reg[0];
    assign torque_y = trq_reg[1];
    assign torque_z = trq_reg[2];
    assign status   = status_reg;

endmodule
